// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/rprt_pkg.sv
package rprt_pkg;

   localparam int TableDepth = 64;
   localparam int AddrW      = $clog2(TableDepth);
   localparam int CntW       = $clog2(TableDepth + 1);
   localparam int LimW       = (CntW > 7) ? CntW : 7;
   localparam int MaxOut     = 64;

   localparam int PnW        = 62;
   localparam int TimeW      = 64;
   localparam int CmdW       = 2;
   localparam int StatusW    = 2;
   localparam int MaxRangesW = 7;
   localparam int CsrIdxW    = 1;
   localparam int CsrDataW   = 7;

   localparam logic [CmdW-1:0] CMD_RECEIVE = 2'd0;
   localparam logic [CmdW-1:0] CMD_CUTOFF  = 2'd1;
   localparam logic [CmdW-1:0] CMD_READ    = 2'd2;

   localparam logic [StatusW-1:0] ST_OK        = 2'd0;
   localparam logic [StatusW-1:0] ST_DUP       = 2'd1;
   localparam logic [StatusW-1:0] ST_EMPTY_ERR = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_IETF_MODE  = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_RANGES = 1'd1;

   localparam int OpW = 5;
   localparam logic [OpW-1:0] OP_NONE      = 5'd0;
   localparam logic [OpW-1:0] OP_CAPTURE   = 5'd1;
   localparam logic [OpW-1:0] OP_RX_FIRST  = 5'd2;
   localparam logic [OpW-1:0] OP_RX_START  = 5'd3;
   localparam logic [OpW-1:0] OP_CUT_START = 5'd4;
   localparam logic [OpW-1:0] OP_RD_START  = 5'd5;
   localparam logic [OpW-1:0] OP_SCAN_NEXT = 5'd6;
   localparam logic [OpW-1:0] OP_SCAN_END  = 5'd7;
   localparam logic [OpW-1:0] OP_RX_LOWER  = 5'd8;
   localparam logic [OpW-1:0] OP_RX_UPPER  = 5'd9;
   localparam logic [OpW-1:0] OP_MRG       = 5'd10;
   localparam logic [OpW-1:0] OP_SHD_READ  = 5'd11;
   localparam logic [OpW-1:0] OP_SHD_WRITE = 5'd12;
   localparam logic [OpW-1:0] OP_SHD_DONE  = 5'd13;
   localparam logic [OpW-1:0] OP_INS_PREP  = 5'd14;
   localparam logic [OpW-1:0] OP_INS_READ  = 5'd15;
   localparam logic [OpW-1:0] OP_INS_WRITE = 5'd16;
   localparam logic [OpW-1:0] OP_INS_DONE  = 5'd17;
   localparam logic [OpW-1:0] OP_CUT_HI    = 5'd18;
   localparam logic [OpW-1:0] OP_CUT_LO    = 5'd19;
   localparam logic [OpW-1:0] OP_EMIT      = 5'd20;
   localparam logic [OpW-1:0] OP_RD_EMIT   = 5'd21;

   typedef struct packed {
      logic [CmdW-1:0]  cmd;
      logic [PnW-1:0]   packet_number;
      logic [TimeW-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [PnW-1:0]     range_low;
      logic [PnW-1:0]     range_high;
      logic               range_valid;
      logic               last_range;
      logic [PnW-1:0]     largest_packet;
      logic [PnW-1:0]     cutoff_value;
      logic [TimeW-1:0]   largest_recv_time;
   } rsp_type;

   typedef struct packed {
      logic [PnW-1:0] lo;
      logic [PnW-1:0] hi;
   } range_type;

   typedef struct packed {
      logic [OpW-1:0]     op;
      logic [StatusW-1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic [CmdW-1:0] cmd;
      logic            used_zero;
      logic            below_cut;
      logic            cut_skip;
      logic            gt_hi1;
      logic            at_lo_m1;
      logic            at_hi_p1;
      logic            ge_lo;
      logic            has_next;
      logic            scan_last;
      logic            cut_gt_hi;
      logic            cut_gt_lo;
      logic            mrg_hit;
      logic            ins_more;
      logic            rd_last;
      logic            out_free;
   } dp_stat_type;

endpackage

// File: rtl/received_packet_range_tracker.sv
// Tracks received packet numbers as up to TableDepth disjoint ranges, highest
// first, in a single-port-write table memory walked by a small sequencer. One
// command is worked at a time. A receive scans the ranges from the highest
// down until it settles at one, where it extends a range, inserts a range or
// merges two; an insert or a merge moves the entries behind it one by one. A
// cutoff scans until it stops at a range, or is ignored; a read emits one range
// per cycle while the output register is free, after a start. Every command
// ends in one result, or one per range for a read, held in an output register
// until taken. The table is not cleared after reset: only entries below the
// range count are ever used.
`include "assert_macros.svh"

module received_packet_range_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rprt_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rprt_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rprt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rprt_pkg::CsrDataW-1:0] csr_wdata
);
   import rprt_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   assign csr_ready = 1'b1;

   rprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   rprt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPL(a_empty_range_zero, clock, reset, rsp_valid && !rsp_data.range_valid,
      rsp_data.range_low == '0 && rsp_data.range_high == '0)
   `ASSERT_IMPL(a_range_ordered, clock, reset, rsp_valid && rsp_data.range_valid,
      rsp_data.range_low <= rsp_data.range_high)

endmodule

// File: rtl/rprt_ram.sv
module rprt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rprt_dp.sv
module rprt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rprt_pkg::dp_cmd_type          dp_cmd,
   output rprt_pkg::dp_stat_type         dp_stat,
   input  rprt_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rprt_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   input  logic [rprt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rprt_pkg::CsrDataW-1:0] csr_wdata
);
   import rprt_pkg::*;

   req_type              req_ff, req_in;
   logic [CntW-1:0]      used_ff, used_in;
   logic [CntW-1:0]      idx_ff, idx_in;
   logic [CntW-1:0]      sh_ff, sh_in;
   logic [PnW-1:0]       cut_ff, cut_in;
   logic                 cut_set_ff, cut_set_in;
   logic [TimeW-1:0]     time_ff, time_in;
   logic [PnW-1:0]       largest_ff, largest_in;
   logic [PnW-1:0]       hi_sav_ff, hi_sav_in;
   logic                 ietf_ff, ietf_in;
   logic [MaxRangesW-1:0] max_ff, max_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 we, re;
   logic [AddrW-1:0]     wa, ra;
   range_type            wd, rd;

   logic [CntW-1:0]      idx_p1, sh_m1, nu, pos;
   logic [LimW-1:0]      max_ext, lim_w;
   logic [CntW-1:0]      lim;
   logic                 full;
   logic [PnW-1:0]       pn;
   logic [PnW:0]         pn_p1, hi_p1;
   logic [PnW-1:0]       largest_out, cut_out;

   rprt_ram #(.Width(2 * PnW), .Depth(TableDepth)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_en   (re),
      .rd_addr (ra),
      .rd_data (rd)
   );

   assign pn      = req_ff.packet_number;
   assign pn_p1   = {1'b0, pn} + 1'b1;
   assign hi_p1   = {1'b0, rd.hi} + 1'b1;
   assign idx_p1  = idx_ff + 1'b1;
   assign sh_m1   = sh_ff - 1'b1;
   assign max_ext = LimW'(max_ff);

   always_comb begin
      if (max_ext == '0 || max_ext > LimW'(TableDepth)) begin
         lim_w = LimW'(TableDepth);
      end else if (max_ext == LimW'(1)) begin
         lim_w = LimW'(2);
      end else begin
         lim_w = max_ext;
      end
   end

   assign lim  = lim_w[CntW-1:0];
   assign full = used_ff >= lim;
   assign nu   = full ? used_ff - 1'b1 : used_ff;
   assign pos  = (idx_ff > nu) ? nu : idx_ff;

   assign largest_out = (used_ff == '0) ? '0 : largest_ff;
   assign cut_out     = cut_set_ff ? cut_ff : '0;

   always_comb begin
      dp_stat.cmd       = req_ff.cmd;
      dp_stat.used_zero = used_ff == '0;
      dp_stat.below_cut = pn < cut_ff;
      dp_stat.cut_skip  = cut_set_ff && (pn <= cut_ff);
      dp_stat.gt_hi1    = {1'b0, pn} > hi_p1;
      dp_stat.at_lo_m1  = pn_p1 == {1'b0, rd.lo};
      dp_stat.at_hi_p1  = {1'b0, pn} == hi_p1;
      dp_stat.ge_lo     = pn >= rd.lo;
      dp_stat.has_next  = ({1'b0, idx_ff} + 1'b1) < {1'b0, used_ff};
      dp_stat.scan_last = ({1'b0, idx_ff} + 1'b1) == {1'b0, used_ff};
      dp_stat.cut_gt_hi = pn > rd.hi;
      dp_stat.cut_gt_lo = pn > rd.lo;
      dp_stat.mrg_hit   = hi_p1 == {1'b0, pn};
      dp_stat.ins_more  = sh_ff > idx_ff;
      dp_stat.rd_last   = dp_stat.scan_last || ((32'(idx_ff) + 32'd1) == 32'(MaxOut));
      dp_stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      req_in       = req_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      sh_in        = sh_ff;
      cut_in       = cut_ff;
      cut_set_in   = cut_set_ff;
      time_in      = time_ff;
      largest_in   = largest_ff;
      hi_sav_in    = hi_sav_ff;
      ietf_in      = ietf_ff;
      max_in       = max_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      we           = 1'b0;
      re           = 1'b0;
      wa           = idx_ff[AddrW-1:0];
      ra           = idx_p1[AddrW-1:0];
      wd           = rd;

      unique case (dp_cmd.op)
         OP_CAPTURE: begin
            req_in = req_data;
         end
         OP_RX_FIRST: begin
            we         = 1'b1;
            wa         = '0;
            wd         = '{lo: pn, hi: pn};
            used_in    = CntW'(1);
            time_in    = req_ff.now_time;
            largest_in = pn;
         end
         OP_RX_START: begin
            if (pn > largest_ff) begin
               time_in = req_ff.now_time;
            end
            idx_in = '0;
            re     = 1'b1;
            ra     = '0;
         end
         OP_CUT_START: begin
            cut_in     = pn;
            cut_set_in = 1'b1;
            idx_in     = '0;
            re         = 1'b1;
            ra         = '0;
         end
         OP_RD_START: begin
            idx_in = '0;
            re     = 1'b1;
            ra     = '0;
         end
         OP_SCAN_NEXT: begin
            idx_in = idx_p1;
            re     = 1'b1;
         end
         OP_SCAN_END: begin
            idx_in = used_ff;
         end
         OP_RX_LOWER: begin
            we        = 1'b1;
            wd        = '{lo: pn, hi: rd.hi};
            hi_sav_in = rd.hi;
            re        = 1'b1;
         end
         OP_RX_UPPER: begin
            we = 1'b1;
            wd = '{lo: rd.lo, hi: pn};
            if (idx_ff == '0) begin
               largest_in = pn;
            end
         end
         OP_MRG: begin
            we     = 1'b1;
            wd     = '{lo: rd.lo, hi: hi_sav_ff};
            idx_in = idx_p1;
         end
         OP_SHD_READ: begin
            re = 1'b1;
         end
         OP_SHD_WRITE: begin
            we     = 1'b1;
            idx_in = idx_p1;
         end
         OP_SHD_DONE: begin
            used_in = used_ff - 1'b1;
         end
         OP_INS_PREP: begin
            used_in = nu;
            sh_in   = nu;
            idx_in  = pos;
         end
         OP_INS_READ: begin
            re = 1'b1;
            ra = sh_m1[AddrW-1:0];
         end
         OP_INS_WRITE: begin
            we    = 1'b1;
            wa    = sh_ff[AddrW-1:0];
            sh_in = sh_m1;
         end
         OP_INS_DONE: begin
            we      = 1'b1;
            wd      = '{lo: pn, hi: pn};
            used_in = used_ff + 1'b1;
            if (idx_ff == '0) begin
               largest_in = pn;
            end
         end
         OP_CUT_HI: begin
            used_in = idx_ff;
         end
         OP_CUT_LO: begin
            we      = 1'b1;
            wd      = '{lo: pn, hi: rd.hi};
            used_in = idx_p1;
         end
         OP_EMIT: begin
            rsp_valid_in             = 1'b1;
            rsp_in.status            = dp_cmd.status;
            rsp_in.range_low         = '0;
            rsp_in.range_high        = '0;
            rsp_in.range_valid       = 1'b0;
            rsp_in.last_range        = 1'b1;
            rsp_in.largest_packet    = largest_out;
            rsp_in.cutoff_value      = cut_out;
            rsp_in.largest_recv_time = time_ff;
         end
         OP_RD_EMIT: begin
            rsp_valid_in             = 1'b1;
            rsp_in.status            = ST_OK;
            rsp_in.range_low         = rd.lo;
            rsp_in.range_high        = rd.hi;
            rsp_in.range_valid       = 1'b1;
            rsp_in.last_range        = dp_stat.rd_last;
            rsp_in.largest_packet    = largest_out;
            rsp_in.cutoff_value      = cut_out;
            rsp_in.largest_recv_time = time_ff;
            idx_in                   = idx_p1;
            re                       = 1'b1;
         end
         default: begin
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_IETF_MODE: begin
               ietf_in = csr_wdata[0];
               if (!cut_set_ff) begin
                  cut_in = {{(PnW-1){1'b0}}, ~csr_wdata[0]};
               end
            end
            CSR_MAX_RANGES: begin
               max_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         cut_ff       <= '0;
         cut_set_ff   <= 1'b0;
         time_ff      <= '0;
         ietf_ff      <= 1'b1;
         max_ff       <= MaxRangesW'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         cut_ff       <= cut_in;
         cut_set_ff   <= cut_set_in;
         time_ff      <= time_in;
         ietf_ff      <= ietf_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      sh_ff      <= sh_in;
      largest_ff <= largest_in;
      hi_sav_ff  <= hi_sav_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/rprt_ctrl.sv
module rprt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rprt_pkg::dp_stat_type dp_stat,
   output rprt_pkg::dp_cmd_type  dp_cmd
);
   import rprt_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_RX_SCAN  = 4'd2;
   localparam logic [3:0] S_MRG      = 4'd3;
   localparam logic [3:0] S_SHD_RD   = 4'd4;
   localparam logic [3:0] S_SHD_WR   = 4'd5;
   localparam logic [3:0] S_INS_PREP = 4'd6;
   localparam logic [3:0] S_INS_RD   = 4'd7;
   localparam logic [3:0] S_INS_WR   = 4'd8;
   localparam logic [3:0] S_CUT_SCAN = 4'd9;
   localparam logic [3:0] S_RD_EMIT  = 4'd10;
   localparam logic [3:0] S_EMIT     = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [StatusW-1:0] st_ff, st_in;
   logic [OpW-1:0]     op;

   assign req_stall     = state_ff != S_IDLE;
   assign dp_cmd.op     = op;
   assign dp_cmd.status = st_ff;

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            st_in    = ST_OK;
            state_in = S_EMIT;
            unique case (dp_stat.cmd)
               CMD_RECEIVE: begin
                  priority if (dp_stat.used_zero && dp_stat.below_cut) begin
                     st_in = ST_EMPTY_ERR;
                  end else if (dp_stat.used_zero) begin
                     op = OP_RX_FIRST;
                  end else if (dp_stat.below_cut) begin
                     st_in = ST_DUP;
                  end else begin
                     op       = OP_RX_START;
                     state_in = S_RX_SCAN;
                  end
               end
               CMD_CUTOFF: begin
                  if (!dp_stat.cut_skip) begin
                     op = OP_CUT_START;
                     if (!dp_stat.used_zero) begin
                        state_in = S_CUT_SCAN;
                     end
                  end
               end
               CMD_READ: begin
                  if (!dp_stat.used_zero) begin
                     op       = OP_RD_START;
                     state_in = S_RD_EMIT;
                  end
               end
               default: begin
               end
            endcase
         end
         S_RX_SCAN: begin
            priority if (dp_stat.gt_hi1) begin
               state_in = S_INS_PREP;
            end else if (dp_stat.at_lo_m1) begin
               op       = OP_RX_LOWER;
               state_in = dp_stat.has_next ? S_MRG : S_EMIT;
            end else if (dp_stat.at_hi_p1) begin
               op       = OP_RX_UPPER;
               state_in = S_EMIT;
            end else if (dp_stat.ge_lo) begin
               st_in    = ST_DUP;
               state_in = S_EMIT;
            end else if (dp_stat.scan_last) begin
               op       = OP_SCAN_END;
               state_in = S_INS_PREP;
            end else begin
               op = OP_SCAN_NEXT;
            end
         end
         S_MRG: begin
            if (dp_stat.mrg_hit) begin
               op       = OP_MRG;
               state_in = S_SHD_RD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SHD_RD: begin
            if (dp_stat.has_next) begin
               op       = OP_SHD_READ;
               state_in = S_SHD_WR;
            end else begin
               op       = OP_SHD_DONE;
               state_in = S_EMIT;
            end
         end
         S_SHD_WR: begin
            op       = OP_SHD_WRITE;
            state_in = S_SHD_RD;
         end
         S_INS_PREP: begin
            op       = OP_INS_PREP;
            state_in = S_INS_RD;
         end
         S_INS_RD: begin
            if (dp_stat.ins_more) begin
               op       = OP_INS_READ;
               state_in = S_INS_WR;
            end else begin
               op       = OP_INS_DONE;
               state_in = S_EMIT;
            end
         end
         S_INS_WR: begin
            op       = OP_INS_WRITE;
            state_in = S_INS_RD;
         end
         S_CUT_SCAN: begin
            priority if (dp_stat.cut_gt_hi) begin
               op       = OP_CUT_HI;
               state_in = S_EMIT;
            end else if (dp_stat.cut_gt_lo) begin
               op       = OP_CUT_LO;
               state_in = S_EMIT;
            end else if (dp_stat.scan_last) begin
               state_in = S_EMIT;
            end else begin
               op = OP_SCAN_NEXT;
            end
         end
         S_RD_EMIT: begin
            if (dp_stat.out_free) begin
               op = OP_RD_EMIT;
               if (dp_stat.rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (dp_stat.out_free) begin
               op       = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

endmodule

// File: tb/sv/tb_received_packet_range_tracker.sv
module tb_received_packet_range_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   import rprt_pkg::*;

   localparam logic [CmdW-1:0] CMD_UNKNOWN = 2'd3;
   localparam int SettleCycles = 400;

   typedef struct {
      req_type item;
      bit      wait_drain;
   } queued_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   received_packet_range_tracker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   queued_cmd_type cmd_queue[$];
   rsp_type        reports_due[$];
   int  mismatches = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  cmd_taken = 1'b0;

   // tracker copy
   logic [PnW-1:0] low_tab[TableDepth];
   logic [PnW-1:0] high_tab[TableDepth];
   int             used_cnt = 0;
   logic [PnW-1:0] cutoff_now = '0;
   bit             cutoff_seen = 1'b0;
   logic [TimeW-1:0] top_time = '0;
   bit             ietf_now = 1'b1;
   int             max_ranges_now = 64;

   function automatic int range_limit();
      if (max_ranges_now == 0 || max_ranges_now > TableDepth) return TableDepth;
      if (max_ranges_now == 1) return 2;
      return max_ranges_now;
   endfunction

   function automatic void insert_range(int pos, logic [PnW-1:0] pn);
      int p;
      p = pos;
      if (used_cnt >= range_limit()) begin
         used_cnt--;
         if (p > used_cnt) p = used_cnt;
      end
      for (int k = used_cnt; k > p; k--) begin
         low_tab[k] = low_tab[k-1];
         high_tab[k] = high_tab[k-1];
      end
      low_tab[p] = pn;
      high_tab[p] = pn;
      used_cnt++;
   endfunction

   function automatic logic [StatusW-1:0] receive_packet(logic [PnW-1:0] pn,
                                                         logic [TimeW-1:0] t);
      logic [PnW:0] hi_p1;
      if (used_cnt == 0) begin
         if (pn < cutoff_now) return ST_EMPTY_ERR;
         low_tab[0] = pn;
         high_tab[0] = pn;
         used_cnt = 1;
         top_time = t;
         return ST_OK;
      end
      if (pn < cutoff_now) return ST_DUP;
      if (pn > high_tab[0]) top_time = t;
      for (int i = 0; i < used_cnt; i++) begin
         hi_p1 = {1'b0, high_tab[i]} + 1'b1;
         if ({1'b0, pn} > hi_p1) begin
            insert_range(i, pn);
            return ST_OK;
         end
         if (low_tab[i] != 0 && pn == low_tab[i] - 1'b1) begin
            low_tab[i] = pn;
            if (i + 1 < used_cnt && {1'b0, high_tab[i+1]} + 1'b1 == {1'b0, pn}) begin
               low_tab[i] = low_tab[i+1];
               for (int k = i + 1; k + 1 < used_cnt; k++) begin
                  low_tab[k] = low_tab[k+1];
                  high_tab[k] = high_tab[k+1];
               end
               used_cnt--;
            end
            return ST_OK;
         end
         if ({1'b0, pn} == hi_p1) begin
            high_tab[i] = pn;
            return ST_OK;
         end
         if (pn >= low_tab[i]) return ST_DUP;
      end
      insert_range(used_cnt, pn);
      return ST_OK;
   endfunction

   function automatic void raise_cutoff(logic [PnW-1:0] c);
      if (cutoff_seen && c <= cutoff_now) return;
      cutoff_now = c;
      cutoff_seen = 1'b1;
      for (int i = 0; i < used_cnt; i++) begin
         if (c > high_tab[i]) begin
            used_cnt = i;
            return;
         end
         if (c > low_tab[i]) begin
            low_tab[i] = c;
            used_cnt = i + 1;
            return;
         end
      end
   endfunction

   function automatic rsp_type make_report(logic [StatusW-1:0] st, logic [PnW-1:0] lo,
                                           logic [PnW-1:0] hi, bit vld, bit last);
      rsp_type r;
      r.status = st;
      r.range_low = lo;
      r.range_high = hi;
      r.range_valid = vld;
      r.last_range = last;
      r.largest_packet = used_cnt != 0 ? high_tab[0] : '0;
      r.cutoff_value = cutoff_seen ? cutoff_now : '0;
      r.largest_recv_time = top_time;
      return r;
   endfunction

   function automatic void track_command(req_type q);
      logic [StatusW-1:0] st;
      int n;
      case (q.cmd)
         CMD_RECEIVE: begin
            st = receive_packet(q.packet_number, q.now_time);
            reports_due.push_back(make_report(st, '0, '0, 1'b0, 1'b1));
         end
         CMD_CUTOFF: begin
            raise_cutoff(q.packet_number);
            reports_due.push_back(make_report(ST_OK, '0, '0, 1'b0, 1'b1));
         end
         CMD_READ: begin
            if (used_cnt == 0) begin
               reports_due.push_back(make_report(ST_OK, '0, '0, 1'b0, 1'b1));
            end else begin
               n = used_cnt < MaxOut ? used_cnt : MaxOut;
               for (int i = 0; i < n; i++)
                  reports_due.push_back(make_report(ST_OK, low_tab[i], high_tab[i],
                                                    1'b1, i + 1 == n));
            end
         end
         default: reports_due.push_back(make_report(ST_OK, '0, '0, 1'b0, 1'b1));
      endcase
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   // driver and idle control
   always @(negedge clock) begin
      logic nv;
      req_type nd;
      queued_cmd_type c;
      nv = req_valid;
      nd = req_data;
      if (!reset && (!req_valid || cmd_taken)) begin
         nv = 1'b0;
         if (cmd_queue.size() > 0 && !(cmd_queue[0].wait_drain && reports_due.size() > 0)
             && $urandom_range(99) >= send_idle_pct) begin
            c = cmd_queue.pop_front();
            nd = c.item;
            nv = 1'b1;
         end
      end
      req_valid <= nv;
      req_data <= nd;
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      cmd_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               report_mismatch("unexpected transfer", 64'd1, 64'd0);
            end else begin
               want = reports_due.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.range_low !== want.range_low)
                  report_mismatch("range_low", rsp_data.range_low, want.range_low);
               if (rsp_data.range_high !== want.range_high)
                  report_mismatch("range_high", rsp_data.range_high, want.range_high);
               if (rsp_data.range_valid !== want.range_valid)
                  report_mismatch("range_valid", rsp_data.range_valid, want.range_valid);
               if (rsp_data.last_range !== want.last_range)
                  report_mismatch("last_range", rsp_data.last_range, want.last_range);
               if (rsp_data.largest_packet !== want.largest_packet)
                  report_mismatch("largest_packet", rsp_data.largest_packet,
                                  want.largest_packet);
               if (rsp_data.cutoff_value !== want.cutoff_value)
                  report_mismatch("cutoff_value", rsp_data.cutoff_value, want.cutoff_value);
               if (rsp_data.largest_recv_time !== want.largest_recv_time)
                  report_mismatch("largest_recv_time", rsp_data.largest_recv_time,
                                  want.largest_recv_time);
            end
         end
         if (req_valid && !req_stall) begin
            track_command(req_data);
            cmd_taken = 1'b1;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_cmd(logic [CmdW-1:0] cmd, logic [PnW-1:0] pn, bit drain = 1'b0);
      queued_cmd_type c;
      c.item.cmd = cmd;
      c.item.packet_number = pn;
      c.item.now_time = rand64();
      c.wait_drain = drain;
      cmd_queue.push_back(c);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_queue.size() != 0 || req_valid || reports_due.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_IETF_MODE) begin
         ietf_now = val[0];
         if (!cutoff_seen) cutoff_now = ietf_now ? '0 : PnW'(1);
      end else begin
         max_ranges_now = int'(val);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count);
      logic [PnW-1:0] base;
      int r, span;
      case ($urandom_range(2))
         0: base = PnW'($urandom_range(200));
         1: base = {PnW{1'b1}} - PnW'($urandom_range(300));
         default: base = PnW'(rand64());
      endcase
      for (int j = 0; j < count; j++) begin
         r = $urandom_range(99);
         span = ($urandom_range(9) == 0) ? 400 : 60;
         if ($urandom_range(15) == 0) base = base + PnW'($urandom_range(30));
         if (r < 70) queue_cmd(CMD_RECEIVE, base + PnW'($urandom_range(span)));
         else if (r < 78) queue_cmd(CMD_CUTOFF, base + PnW'($urandom_range(span / 3)));
         else if (r < 90) queue_cmd(CMD_READ, PnW'(rand64()));
         else if (r < 95) queue_cmd(CMD_RECEIVE, PnW'(rand64()));
         else if (r < 97) queue_cmd(CMD_CUTOFF, PnW'(rand64()));
         else queue_cmd(CMD_UNKNOWN, PnW'(rand64()));
      end
   endtask

   initial begin
      logic [PnW-1:0] top;
      top = {PnW{1'b1}};
      send_idle_pct = 14;
      recv_idle_pct = 57;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_cmd(CMD_READ, '0);
      wait_idle();
      csr_write(CSR_IETF_MODE, 7'd0);
      queue_cmd(CMD_RECEIVE, '0);
      queue_cmd(CMD_RECEIVE, 62'd5);
      queue_cmd(CMD_RECEIVE, 62'd7);
      queue_cmd(CMD_RECEIVE, 62'd6);
      queue_cmd(CMD_RECEIVE, 62'd4);
      queue_cmd(CMD_RECEIVE, 62'd8);
      queue_cmd(CMD_RECEIVE, 62'd6);
      queue_cmd(CMD_RECEIVE, '0);
      queue_cmd(CMD_RECEIVE, 62'd1);
      queue_cmd(CMD_RECEIVE, top);
      queue_cmd(CMD_RECEIVE, top - 62'd2);
      queue_cmd(CMD_READ, '0, 1'b1);
      queue_cmd(CMD_CUTOFF, 62'd5);
      queue_cmd(CMD_CUTOFF, 62'd3);
      queue_cmd(CMD_READ, '0);
      queue_cmd(CMD_UNKNOWN, top);
      queue_cmd(CMD_CUTOFF, top - 62'd1);
      queue_cmd(CMD_READ, '0);
      queue_cmd(CMD_CUTOFF, top);
      queue_cmd(CMD_RECEIVE, 62'd9);
      queue_cmd(CMD_READ, '0);
      wait_idle();
      csr_write(CSR_IETF_MODE, 7'd1);
      csr_write(CSR_MAX_RANGES, 7'd2);
      random_phase(37);
      wait_idle();
      csr_write(CSR_MAX_RANGES, 7'd1);
      random_phase(37);
      wait_idle();
      send_idle_pct = 57;
      recv_idle_pct = 14;
      csr_write(CSR_MAX_RANGES, 7'd0);
      csr_write(CSR_IETF_MODE, 7'd0);
      random_phase(37);
      wait_idle();
      csr_write(CSR_MAX_RANGES, 7'd127);
      random_phase(37);
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(CSR_MAX_RANGES, 7'd64);
      random_phase(37);
      wait_idle();
      csr_write(CSR_MAX_RANGES, 7'd5);
      random_phase(37);
      wait_idle();

      if (mismatches == 0 && reports_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
